@@ hdl/cpbf_pkg.sv @@
package cpbf_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DsqW   = 33;
	localparam int unsigned DistW  = 25;
	localparam int unsigned FracW  = 8;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
	} in_t;

	typedef struct packed {
		logic        [IdxW-1:0]   first_index;
		logic        [IdxW-1:0]   second_index;
		logic signed [CoordW-1:0] first_x;
		logic signed [CoordW-1:0] first_y;
		logic signed [CoordW-1:0] second_x;
		logic signed [CoordW-1:0] second_y;
		logic        [DsqW-1:0]   min_dist_sq;
		logic        [DistW-1:0]  min_dist;
	} out_t;

	// Handshake between the sequencer and an iterative unit
	typedef struct packed {
		logic go;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

@@ hdl/cpbf_dist.sv @@
module cpbf_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpbf_pkg::unit_req_t           req,
	input  cpbf_pkg::in_t                 pa,
	input  cpbf_pkg::in_t                 pb,
	output cpbf_pkg::unit_rsp_t           rsp,
	output logic [cpbf_pkg::DsqW-1:0]     dsq
);

	typedef enum logic [1:0] {PH_IDLE, PH_DX, PH_DY} phase_t;

	localparam int unsigned CW = cpbf_pkg::CoordW;

	phase_t              phase_q;
	logic [CW-1:0]       dx_q;
	logic [CW-1:0]       dy_q;
	logic [2*CW-1:0]     acc_q;
	logic [cpbf_pkg::DsqW-1:0] dsq_q;
	logic                done_q;

	logic signed [CW:0]  diff_x;
	logic signed [CW:0]  diff_y;
	logic [CW:0]         neg_x;
	logic [CW:0]         neg_y;
	logic [CW-1:0]       abs_x;
	logic [CW-1:0]       abs_y;
	logic [CW-1:0]       mul_op;
	logic [2*CW-1:0]     prod;

	assign diff_x = {pb.point_x[CW-1], pb.point_x} - {pa.point_x[CW-1], pa.point_x};
	assign diff_y = {pb.point_y[CW-1], pb.point_y} - {pa.point_y[CW-1], pa.point_y};
	assign neg_x  = -diff_x;
	assign neg_y  = -diff_y;
	assign abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
	assign abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

	// One squarer, shared between the two axes
	assign mul_op = (phase_q == PH_DY) ? dy_q : dx_q;
	assign prod   = mul_op * mul_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (req.go) begin
						phase_q <= PH_DX;
					end
				end
				PH_DX: begin
					phase_q <= PH_DY;
				end
				PH_DY: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.go) begin
			dx_q <= abs_x;
			dy_q <= abs_y;
		end
		if (phase_q == PH_DX) begin
			acc_q <= prod;
		end
		if (phase_q == PH_DY) begin
			dsq_q <= {1'b0, acc_q} + {1'b0, prod};
		end
	end

	assign rsp.done = done_q;
	assign dsq      = dsq_q;

endmodule

@@ hdl/cpbf_isqrt.sv @@
module cpbf_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpbf_pkg::unit_req_t           req,
	input  logic [cpbf_pkg::DsqW-1:0]     operand,
	output cpbf_pkg::unit_rsp_t           rsp,
	output logic [cpbf_pkg::DistW-1:0]    root
);

	localparam int unsigned RW   = cpbf_pkg::DistW;
	localparam int unsigned VW   = 2 * RW;
	localparam int unsigned PadW = VW - cpbf_pkg::DsqW - 2 * cpbf_pkg::FracW;
	localparam int unsigned CntW = $clog2(RW);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [VW-1:0]   val_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;

	logic [RW+2:0]   rem_sh;
	logic [RW+2:0]   trial;
	logic [RW+2:0]   diff;
	logic            take;

	// One result bit per step: bring down two operand bits, try root*4+1
	assign rem_sh = {rem_q, val_q[VW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CntW'(RW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go && !run_q) begin
			val_q  <= {{PadW{1'b0}}, operand, {(2 * cpbf_pkg::FracW){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[VW-3:0], 2'b00};
			rem_q  <= take ? diff[RW:0] : rem_sh[RW:0];
			root_q <= {root_q[RW-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign root     = root_q;

endmodule

@@ hdl/closest_pair_brute_force_core.sv @@
// Loading: one point per cycle, start is taken whenever busy is low.
// After the last point of a set, busy stays high while every pair passes through
// the shared squarer and then through the 25 steps of the bit-serial square root.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset clears the sequencer, the load count and done; the point store is not cleared.
module closest_pair_brute_force_core #(
	parameter int unsigned NUM_POINTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cpbf_pkg::in_t  point,
	output logic           busy,
	output logic           done,
	output cpbf_pkg::out_t result
);

	localparam int unsigned IW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int unsigned BW = cpbf_pkg::DsqW + 1;

	typedef enum logic [2:0] {
		S_LOAD, S_RDI, S_LATI, S_RDJ, S_GO, S_WAIT, S_ROOT, S_ROOTW
	} state_t;

	state_t              state_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       i_q;
	logic [IW-1:0]       j_q;
	logic [IW-1:0]       rd_addr;
	cpbf_pkg::in_t       mem [NUM_POINTS];
	cpbf_pkg::in_t       rd_q;
	cpbf_pkg::in_t       pi_q;
	cpbf_pkg::in_t       best_a_q;
	cpbf_pkg::in_t       best_b_q;
	logic [IW-1:0]       best_i_q;
	logic [IW-1:0]       best_j_q;
	logic [BW-1:0]       best_d_q;
	logic                done_q;
	cpbf_pkg::out_t      result_q;

	cpbf_pkg::unit_req_t dist_req;
	cpbf_pkg::unit_rsp_t dist_rsp;
	cpbf_pkg::unit_req_t root_req;
	cpbf_pkg::unit_rsp_t root_rsp;
	logic [cpbf_pkg::DsqW-1:0]  dsq;
	logic [cpbf_pkg::DistW-1:0] root;

	logic                accept;
	logic                better;
	logic [IW+2:0]       ext_i;
	logic [IW+2:0]       ext_j;

	assign accept      = start && (state_q == S_LOAD);
	assign rd_addr     = (state_q == S_RDI) ? i_q : j_q;
	assign dist_req.go = (state_q == S_GO);
	assign root_req.go = (state_q == S_ROOT);
	assign better      = ({1'b0, dsq} < best_d_q);
	assign ext_i       = (IW + 3)'(best_i_q);
	assign ext_j       = (IW + 3)'(best_j_q);

	cpbf_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dist_req),
		.pa     (pi_q),
		.pb     (rd_q),
		.rsp    (dist_rsp),
		.dsq    (dsq)
	);

	cpbf_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (root_req),
		.operand (best_d_q[cpbf_pkg::DsqW-1:0]),
		.rsp     (root_rsp),
		.root    (root)
	);

	// Point store: one write port for loading, one registered read port
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[cnt_q] <= point;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			best_i_q <= '0;
			best_j_q <= '0;
			best_d_q <= '1;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (cnt_q == IW'(NUM_POINTS - 1)) begin
							cnt_q    <= '0;
							i_q      <= '0;
							best_i_q <= '0;
							best_j_q <= '0;
							best_d_q <= '1;
							state_q  <= S_RDI;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_RDI: begin
					state_q <= S_LATI;
				end
				S_LATI: begin
					pi_q    <= rd_q;
					j_q     <= i_q + 1'b1;
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					state_q <= S_GO;
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (dist_rsp.done) begin
						// strict less-than keeps the earliest minimal pair
						if (better) begin
							best_d_q <= {1'b0, dsq};
							best_i_q <= i_q;
							best_j_q <= j_q;
							best_a_q <= pi_q;
							best_b_q <= rd_q;
						end
						if (j_q == IW'(NUM_POINTS - 1)) begin
							if (i_q == IW'(NUM_POINTS - 2)) begin
								state_q <= S_ROOT;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= S_RDI;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RDJ;
						end
					end
				end
				S_ROOT: begin
					state_q <= S_ROOTW;
				end
				S_ROOTW: begin
					if (root_rsp.done) begin
						result_q.first_index  <= ext_i[2:0];
						result_q.second_index <= ext_j[2:0];
						result_q.first_x      <= best_a_q.point_x;
						result_q.first_y      <= best_a_q.point_y;
						result_q.second_x     <= best_b_q.point_x;
						result_q.second_y     <= best_b_q.point_y;
						result_q.min_dist_sq  <= best_d_q[cpbf_pkg::DsqW-1:0];
						result_q.min_dist     <= root;
						done_q  <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_LOAD);
	assign done   = done_q;
	assign result = result_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("compute finished without a result");

	a_best_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROOT) |-> (best_d_q[BW-1] == 1'b0) && (best_i_q < best_j_q))
		else $error("no valid pair recorded before square root");

endmodule

@@ tb/closest_pair_checker.sv @@
`timescale 1ns / 1ps

module closest_pair_checker #(
	parameter int unsigned NUM_POINTS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  cpbf_pkg::in_t  point,
	input  logic           done,
	input  cpbf_pkg::out_t result,
	output int             mismatches,
	output int             pending
);

	logic signed [cpbf_pkg::CoordW-1:0] set_x [NUM_POINTS];
	logic signed [cpbf_pkg::CoordW-1:0] set_y [NUM_POINTS];
	int unsigned                        fill;
	cpbf_pkg::out_t                     expected_pairs [$];

	// Bit-by-bit floor(sqrt(dsq * 2^16)), i.e. the distance with 8 fraction bits
	function automatic logic [cpbf_pkg::DistW-1:0] root_q8(
		input logic [cpbf_pkg::DsqW-1:0] dsq);
		longint unsigned radicand;
		longint unsigned root;
		longint unsigned trial;
		radicand = longint'(dsq) << (2 * cpbf_pkg::FracW);
		root     = 0;
		for (int b = cpbf_pkg::DistW - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) begin
				root = trial;
			end
		end
		return root[cpbf_pkg::DistW-1:0];
	endfunction

	function automatic cpbf_pkg::out_t closest_pair();
		cpbf_pkg::out_t  best_pair;
		logic [33:0]     best_dsq;
		longint signed   dx;
		longint signed   dy;
		longint unsigned dsq;
		int unsigned     bi;
		int unsigned     bj;
		best_dsq = '1;
		bi       = 0;
		bj       = 0;
		for (int unsigned i = 0; i + 1 < NUM_POINTS; i++) begin
			for (int unsigned j = i + 1; j < NUM_POINTS; j++) begin
				dx  = longint'(set_x[j]) - longint'(set_x[i]);
				dy  = longint'(set_y[j]) - longint'(set_y[i]);
				dsq = dx * dx + dy * dy;
				// strict compare keeps the earliest pair on a tie
				if (dsq < best_dsq) begin
					best_dsq = dsq[33:0];
					bi       = i;
					bj       = j;
				end
			end
		end
		best_pair.first_index  = bi[cpbf_pkg::IdxW-1:0];
		best_pair.second_index = bj[cpbf_pkg::IdxW-1:0];
		best_pair.first_x      = set_x[bi];
		best_pair.first_y      = set_y[bi];
		best_pair.second_x     = set_x[bj];
		best_pair.second_y     = set_y[bj];
		best_pair.min_dist_sq  = best_dsq[cpbf_pkg::DsqW-1:0];
		best_pair.min_dist     = root_q8(best_dsq[cpbf_pkg::DsqW-1:0]);
		return best_pair;
	endfunction

	task automatic compare_field(input string name, input longint exp_val,
		input longint got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cpbf_pkg::out_t exp_pair;
		if (!arst_n) begin
			fill = 0;
			expected_pairs.delete();
		end else begin
			if (done) begin
				if (expected_pairs.size() == 0) begin
					$error("result: unexpected transaction, nothing pending");
					mismatches++;
				end else begin
					exp_pair = expected_pairs.pop_front();
					compare_field("first_index", longint'(exp_pair.first_index),
						longint'(result.first_index));
					compare_field("second_index", longint'(exp_pair.second_index),
						longint'(result.second_index));
					compare_field("first_x", longint'(exp_pair.first_x),
						longint'(result.first_x));
					compare_field("first_y", longint'(exp_pair.first_y),
						longint'(result.first_y));
					compare_field("second_x", longint'(exp_pair.second_x),
						longint'(result.second_x));
					compare_field("second_y", longint'(exp_pair.second_y),
						longint'(result.second_y));
					compare_field("min_dist_sq", longint'(exp_pair.min_dist_sq),
						longint'(result.min_dist_sq));
					compare_field("min_dist", longint'(exp_pair.min_dist),
						longint'(result.min_dist));
				end
			end
			if (start && !busy) begin
				set_x[fill] = point.point_x;
				set_y[fill] = point.point_y;
				fill++;
				if (fill == NUM_POINTS) begin
					expected_pairs.push_back(closest_pair());
					fill = 0;
				end
			end
		end
		pending = expected_pairs.size();
	end

endmodule

@@ tb/tb_closest_pair_brute_force_core.sv @@
`timescale 1ns / 1ps

module tb_closest_pair_brute_force_core;

	localparam int unsigned NumPoints  = 8;
	localparam int          RandomSets = 191;
	localparam int          DrainCycles = 250;
	localparam int          CycleLimit = 400_000;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	cpbf_pkg::in_t  point;
	logic           busy;
	logic           done;
	cpbf_pkg::out_t result;

	int             mismatches;
	int             pending;
	int             cycle_count = 0;
	bit             idle_enable = 1'b1;
	cpbf_pkg::in_t  set_buf [NumPoints];

	closest_pair_brute_force_core #(
		.NUM_POINTS(NumPoints)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.point (point),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	closest_pair_checker #(
		.NUM_POINTS(NumPoints)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.done      (done),
		.result    (result),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [cpbf_pkg::CoordW-1:0] clip16(input int v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[cpbf_pkg::CoordW-1:0];
	endfunction

	function automatic cpbf_pkg::in_t pt(input int x, input int y);
		cpbf_pkg::in_t p;
		p.point_x = clip16(x);
		p.point_y = clip16(y);
		return p;
	endfunction

	function automatic int rail_coord();
		unique case ($urandom_range(0, 6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	// Drive one point and hold it until the block takes the transaction
	task automatic send_point(input cpbf_pkg::in_t p);
		while (idle_enable && $urandom_range(0, 99) < 24) begin
			start <= 1'b0;
			point <= cpbf_pkg::in_t'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic send_set();
		for (int k = 0; k < NumPoints; k++) begin
			send_point(set_buf[k]);
		end
	endtask

	task automatic fill_random_set();
		int mode;
		int cx;
		int cy;
		int spread;
		mode   = $urandom_range(0, 4);
		cx     = int'($urandom_range(0, 65535)) - 32768;
		cy     = int'($urandom_range(0, 65535)) - 32768;
		spread = 1 << $urandom_range(1, 10);
		for (int k = 0; k < NumPoints; k++) begin
			unique case (mode)
				0: set_buf[k] = cpbf_pkg::in_t'($urandom);
				1: set_buf[k] = pt(cx + int'($urandom_range(0, spread)) - spread / 2,
					cy + int'($urandom_range(0, spread)) - spread / 2);
				2: set_buf[k] = pt(rail_coord(), rail_coord());
				3: set_buf[k] = cpbf_pkg::in_t'($urandom);
				default: set_buf[k] = pt(int'($urandom_range(0, 3)) - 2,
					int'($urandom_range(0, 3)) - 2);
			endcase
		end
		// plant a duplicate so zero distance shows up at random positions
		if (mode == 3) begin
			set_buf[$urandom_range(0, NumPoints - 1)] =
				set_buf[$urandom_range(0, NumPoints - 1)];
		end
	endtask

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_closest_pair_brute_force_core: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		point  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners and axis extremes
		set_buf[0] = pt(-32768, -32768);
		set_buf[1] = pt(32767, 32767);
		set_buf[2] = pt(-32768, 32767);
		set_buf[3] = pt(32767, -32768);
		set_buf[4] = pt(0, 0);
		set_buf[5] = pt(-32768, 0);
		set_buf[6] = pt(32767, 0);
		set_buf[7] = pt(0, -32768);
		send_set();

		// all points equal: zero distance, first pair wins
		for (int k = 0; k < NumPoints; k++) begin
			set_buf[k] = pt(-32768, 32767);
		end
		send_set();

		// several pairs tie at distance 5, the earliest one must win
		set_buf[0] = pt(1000, 1000);
		set_buf[1] = pt(-1000, -1000);
		set_buf[2] = pt(0, 0);
		set_buf[3] = pt(3, 4);
		set_buf[4] = pt(-3, -4);
		set_buf[5] = pt(3, -4);
		set_buf[6] = pt(20000, 20000);
		set_buf[7] = pt(20003, 19996);
		send_set();

		for (int s = 0; s < RandomSets; s++) begin
			idle_enable = !(s >= 60 && s < 90);
			fill_random_set();
			send_set();
		end
		start <= 1'b0;
		point <= cpbf_pkg::in_t'($urandom);

		while (pending != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (mismatches == 0) begin
			$display("tb_closest_pair_brute_force_core: clean");
		end else begin
			$display("tb_closest_pair_brute_force_core: errors");
		end
		$finish;
	end

endmodule
